// ===== rtl/ccd_pkg.sv =====
package ccd_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COLOR_W  = 3 * CHAN_W;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned HIT_W    = 4;
  localparam int unsigned SETTLE_W = 3;
  localparam int unsigned TOL_W    = 8;
  localparam int unsigned MS_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SUM_W    = CHAN_W + 2;

  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_TARGET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS      = 3'd4;

  localparam logic [THR_W-1:0]    RST_DIFF_THRESHOLD  = 8'd35;
  localparam logic [HIT_W-1:0]    RST_HIT_TARGET      = 4'd10;
  localparam logic [SETTLE_W-1:0] RST_SETTLE_COUNT    = 3'd4;
  localparam logic [TOL_W-1:0]    RST_MATCH_TOLERANCE = 8'd20;
  localparam logic [MS_W-1:0]     RST_TIMEOUT_MS      = 24'd0;

  typedef enum logic [1:0] {
    OP_START,
    OP_SAMPLE,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0]    diff_threshold;
    logic [HIT_W-1:0]    hit_target;
    logic [SETTLE_W-1:0] settle_count;
    logic [TOL_W-1:0]    match_tolerance;
    logic [MS_W-1:0]     timeout_ms;
  } cfg_t;

  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/color_contrast_detector.sv =====
// channel | handshake          | payload
// --------+--------------------+-----------------------------------------
// in      | in_valid/in_ready  | kind, red, green, blue
// out     | out_valid/out_ready| outcome, ref_red, ref_green, ref_blue
// cfg     | cfg_we             | cfg_index, cfg_data
//
// one request per cycle while in_ready is high; the back end handles each request in the cycle it is popped
// the request that ends the search passes the front register and the queue, and its result is registered at the output
// rst is synchronous and active high; it clears the search state and reloads config defaults
// a stalled result holds the back end; the two-entry queue keeps in_ready up
// until the front register and queue are both full
module color_contrast_detector
  import ccd_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     kind,
  input  logic [CHAN_W-1:0]     red,
  input  logic [CHAN_W-1:0]     green,
  input  logic [CHAN_W-1:0]     blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  outcome,
  output logic [CHAN_W-1:0]     ref_red,
  output logic [CHAN_W-1:0]     ref_green,
  output logic [CHAN_W-1:0]     ref_blue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  push_ready;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold  <= RST_DIFF_THRESHOLD;
      cfg.hit_target      <= RST_HIT_TARGET;
      cfg.settle_count    <= RST_SETTLE_COUNT;
      cfg.match_tolerance <= RST_MATCH_TOLERANCE;
      cfg.timeout_ms      <= RST_TIMEOUT_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIFF_THRESHOLD:  cfg.diff_threshold  <= cfg_data[THR_W-1:0];
        REG_HIT_TARGET:      cfg.hit_target      <= cfg_data[HIT_W-1:0];
        REG_SETTLE_COUNT:    cfg.settle_count    <= cfg_data[SETTLE_W-1:0];
        REG_MATCH_TOLERANCE: cfg.match_tolerance <= cfg_data[TOL_W-1:0];
        REG_TIMEOUT_MS:      cfg.timeout_ms      <= cfg_data[MS_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  ccd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  ccd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  ccd_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item       (q_item),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .outcome    (outcome),
    .ref_red    (ref_red),
    .ref_green  (ref_green),
    .ref_blue   (ref_blue)
  );

endmodule

// ===== rtl/ccd_front.sv =====
module ccd_front
  import ccd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              push,
  output item_t             push_item,
  input  logic              push_ready
);

  logic  held;
  item_t item;
  item_t item_next;
  logic  known;

  always_comb begin
    item_next.red   = red;
    item_next.green = green;
    item_next.blue  = blue;
    known           = 1'b1;
    unique case (kind)
      KIND_START:  item_next.op = OP_START;
      KIND_SAMPLE: item_next.op = OP_SAMPLE;
      KIND_TICK:   item_next.op = OP_TICK;
      default: begin
        item_next.op = OP_TICK;
        known        = 1'b0;
      end
    endcase
  end

  assign in_ready  = !held || push_ready;
  assign push      = held && push_ready;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= known;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/ccd_queue.sv =====
module ccd_queue
  import ccd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/ccd_back.sv =====
module ccd_back
  import ccd_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_valid,
  input  item_t             item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              outcome,
  output logic [CHAN_W-1:0] ref_red,
  output logic [CHAN_W-1:0] ref_green,
  output logic [CHAN_W-1:0] ref_blue
);

  localparam int unsigned IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_DEPTH - 1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SETTLE = 2'd2;
  localparam logic [1:0] PH_SEARCH = 2'd3;

  logic [1:0]            phase, phase_next;
  logic [COLOR_W-1:0]    ref_color, ref_color_next;
  logic [SETTLE_W-1:0]   match_run, match_run_next;
  logic [IDX_W-1:0]      line_index, line_index_next;
  logic [HIT_W-1:0]      hit_total, hit_total_next;
  logic [MS_W-1:0]       elapsed, elapsed_next;
  logic [LINE_DEPTH-1:0] written, written_next;

  logic [COLOR_W-1:0]    line_mem [LINE_DEPTH];
  logic [COLOR_W-1:0]    rd_data;
  logic                  mem_we;

  logic [COLOR_W-1:0]    sample;
  logic [COLOR_W-1:0]    past;
  logic [CHAN_W-1:0]     d_red, d_green, d_blue;
  logic [SUM_W-1:0]      diff_sum;
  logic [SUM_W-1:0]      hit_bound;
  logic                  hit;
  logic                  same;
  logic [SETTLE_W-1:0]   run_inc;
  logic [HIT_W-1:0]      hits_inc;
  logic [MS_W-1:0]       ms_inc;
  logic                  report;
  logic                  report_kind;

  assign pop    = item_valid && (!out_valid || out_ready);
  assign sample = {item.red, item.green, item.blue};
  assign past   = written[line_index] ? rd_data : ref_color;

  assign d_red     = absdiff(sample[2*CHAN_W +: CHAN_W], past[2*CHAN_W +: CHAN_W]);
  assign d_green   = absdiff(sample[CHAN_W +: CHAN_W], past[CHAN_W +: CHAN_W]);
  assign d_blue    = absdiff(sample[0 +: CHAN_W], past[0 +: CHAN_W]);
  assign diff_sum  = SUM_W'(d_red) + SUM_W'(d_green) + SUM_W'(d_blue);
  // floor(sum / 3) > thr  <=>  sum > 3 * thr + 2
  assign hit_bound = (SUM_W'(cfg.diff_threshold) << 1) + SUM_W'(cfg.diff_threshold)
                     + SUM_W'(2);
  assign hit       = diff_sum > hit_bound;

  assign same =
    (absdiff(ref_color[2*CHAN_W +: CHAN_W], sample[2*CHAN_W +: CHAN_W])
       <= cfg.match_tolerance) &&
    (absdiff(ref_color[CHAN_W +: CHAN_W], sample[CHAN_W +: CHAN_W])
       <= cfg.match_tolerance) &&
    (absdiff(ref_color[0 +: CHAN_W], sample[0 +: CHAN_W]) <= cfg.match_tolerance);

  assign run_inc  = match_run + SETTLE_W'(1);
  assign hits_inc = hit ? hit_total + HIT_W'(1) : hit_total;
  assign ms_inc   = (elapsed == '1) ? elapsed : elapsed + MS_W'(1);

  always_comb begin
    phase_next      = phase;
    ref_color_next  = ref_color;
    match_run_next  = match_run;
    line_index_next = line_index;
    hit_total_next  = hit_total;
    elapsed_next    = elapsed;
    written_next    = written;
    mem_we          = 1'b0;
    report          = 1'b0;
    report_kind     = 1'b0;
    if (pop) begin
      unique case (item.op)
        OP_START: begin
          phase_next     = PH_FIRST;
          match_run_next = '0;
        end
        OP_SAMPLE: begin
          unique case (phase)
            PH_FIRST: begin
              ref_color_next = sample;
              match_run_next = '0;
              if (cfg.settle_count == '0) begin
                phase_next      = PH_SEARCH;
                written_next    = '0;
                line_index_next = '0;
                hit_total_next  = '0;
                elapsed_next    = '0;
              end else begin
                phase_next = PH_SETTLE;
              end
            end
            PH_SETTLE: begin
              if (same) begin
                match_run_next = run_inc;
                if (run_inc >= cfg.settle_count) begin
                  phase_next      = PH_SEARCH;
                  written_next    = '0;
                  line_index_next = '0;
                  hit_total_next  = '0;
                  elapsed_next    = '0;
                end
              end else begin
                ref_color_next = sample;
                match_run_next = '0;
              end
            end
            PH_SEARCH: begin
              hit_total_next = hits_inc;
              if (hit) begin
                elapsed_next = '0;
              end
              if (hits_inc == cfg.hit_target) begin
                report      = 1'b1;
                report_kind = 1'b0;
                phase_next  = PH_IDLE;
              end else begin
                mem_we                   = 1'b1;
                written_next[line_index] = 1'b1;
                line_index_next = (line_index == LAST_IDX) ? '0 : line_index + IDX_W'(1);
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
        OP_TICK: begin
          if (phase == PH_SEARCH) begin
            elapsed_next = ms_inc;
            if ((cfg.timeout_ms != '0) && (ms_inc >= cfg.timeout_ms)) begin
              report      = 1'b1;
              report_kind = 1'b1;
              phase_next  = PH_IDLE;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ref_color  <= '0;
      match_run  <= '0;
      line_index <= '0;
      hit_total  <= '0;
      elapsed    <= '0;
      written    <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      ref_color  <= ref_color_next;
      match_run  <= match_run_next;
      line_index <= line_index_next;
      hit_total  <= hit_total_next;
      elapsed    <= elapsed_next;
      written    <= written_next;
      if (report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      outcome   <= report_kind;
      ref_red   <= ref_color[2*CHAN_W +: CHAN_W];
      ref_green <= ref_color[CHAN_W +: CHAN_W];
      ref_blue  <= ref_color[0 +: CHAN_W];
    end
  end

  // next entry is fetched ahead; with LINE_DEPTH above 1 it never equals the entry written this cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[line_index] <= sample;
    end
    rd_data <= line_mem[line_index_next];
  end

endmodule

// ===== rtl/ccd_checker.sv =====
module ccd_checker
  import ccd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              outcome,
  input logic [CHAN_W-1:0] ref_red,
  input logic [CHAN_W-1:0] ref_green,
  input logic [CHAN_W-1:0] ref_blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(ref_red)
      && $stable(ref_green) && $stable(ref_blue))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind color_contrast_detector ccd_checker u_ccd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .outcome   (outcome),
  .ref_red   (ref_red),
  .ref_green (ref_green),
  .ref_blue  (ref_blue)
);
